// ===== sv/tesq_pkg.sv =====
// Package for the timed event sorted queue: constants, types and codes.
`timescale 1ns / 1ps
`default_nettype none
package tesq_pkg;

   localparam int QueueDepth   = 16;
   localparam int MaxResults   = 16;
   localparam int ChannelCount = 16;
   localparam int CountWidth   = $clog2(QueueDepth + 1);
   localparam int RelWidth     = $clog2(MaxResults + 1);

   localparam logic [1:0] OUTCOME_LISTENER = 2'd0;
   localparam logic [1:0] OUTCOME_NO_LISTENER = 2'd1;
   localparam logic [1:0] OUTCOME_DROPPED = 2'd2;

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef struct packed {
      logic [15:0] delay;
      logic [7:0]  status;
      logic [7:0]  data_one;
      logic [7:0]  data_two;
   } entry_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_SHIFT,
      OP_DECR
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_RELEASE
   } state_type;

endpackage
`default_nettype wire

// ===== sv/tesq_cell.sv =====
// One queue cell: holds one event and moves it to or from its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module tesq_cell (
   input  wire logic                  clock,
   input  wire tesq_pkg::cell_op_type op,
   input  wire logic                  occupied,
   input  wire tesq_pkg::entry_type   new_entry,
   input  wire tesq_pkg::entry_type   left_entry,
   input  wire tesq_pkg::entry_type   right_entry,
   input  wire logic                  left_after,
   output tesq_pkg::entry_type        entry,
   output logic                       after
);

   tesq_pkg::entry_type entry_ff;
   tesq_pkg::entry_type entry_in;

   // at or past the insert point: empty, or strictly later than the new event
   assign after = !occupied || (entry_ff.delay > new_entry.delay);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (op)
         tesq_pkg::OP_HOLD: begin
            entry_in = entry_ff;
         end
         tesq_pkg::OP_INSERT: begin
            if (after) begin
               entry_in = left_after ? left_entry : new_entry;
            end
         end
         tesq_pkg::OP_SHIFT: begin
            entry_in = right_entry;
         end
         tesq_pkg::OP_DECR: begin
            entry_in.delay = entry_ff.delay - 16'd1;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

// ===== sv/timed_event_sorted_queue.sv =====
// Top level of the timed event sorted queue: control, cell chain, result register.
`timescale 1ns / 1ps
`default_nettype none
// Events sit in a row of cells sorted by delay; an add inserts in place,
// each cell taking either its own event, its left neighbor's, or the new one.
// An add is taken while idle and busy stays low. A tick moves to a release
// state: each released event is given up by the front cell while the row
// shifts left, then a final step applies the delay decrement to every cell
// unless the queue is empty or the front delay is already zero; busy is high
// from after the tick is accepted until that final step.
// Results appear for exactly one cycle with rsp_valid and cannot be held off;
// rsp_last marks the final result of an item. csr writes are always ready.
module timed_event_sorted_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_kind,
   input  wire logic [15:0] req_delay,
   input  wire logic [7:0]  req_status_byte,
   input  wire logic [7:0]  req_data_one,
   input  wire logic [7:0]  req_data_two,
   input  wire logic [15:0] req_now_time,
   output logic             rsp_valid,
   output logic [1:0]       rsp_outcome,
   output logic [3:0]       rsp_channel,
   output logic [7:0]       rsp_out_status,
   output logic [7:0]       rsp_out_data_one,
   output logic [7:0]       rsp_out_data_two,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [tesq_pkg::ChannelCount-1:0] csr_wdata
);

   localparam int Depth = tesq_pkg::QueueDepth;
   localparam int CW    = tesq_pkg::CountWidth;
   localparam int RW    = tesq_pkg::RelWidth;

   tesq_pkg::state_type   state_ff, state_in;
   tesq_pkg::cell_op_type op;
   logic [CW-1:0]         count_ff, count_in;
   logic [RW-1:0]         rel_ff, rel_in;
   logic [15:0]           now_ff, now_in;
   logic [tesq_pkg::ChannelCount-1:0] mask_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_outcome_ff, rsp_outcome_in;
   logic [7:0]            rsp_status_ff, rsp_status_in;
   logic [7:0]            rsp_data_one_ff, rsp_data_one_in;
   logic [7:0]            rsp_data_two_ff, rsp_data_two_in;
   logic                  rsp_last_ff, rsp_last_in;

   tesq_pkg::entry_type   new_entry;
   tesq_pkg::entry_type   cell_q [Depth];
   logic [Depth-1:0]      after;
   logic [Depth-1:0]      occupied;

   logic                  accept;
   logic                  full;
   logic                  front_due;
   logic                  next_due;

   assign busy      = (state_ff != tesq_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign full      = (count_ff == CW'(Depth));

   assign new_entry.delay    = req_delay;
   assign new_entry.status   = req_status_byte;
   assign new_entry.data_one = req_data_one;
   assign new_entry.data_two = req_data_two;

   genvar g;
   generate
      for (g = 0; g < Depth; g++) begin : g_cell
         assign occupied[g] = (CW'(g) < count_ff);
         if (g == 0) begin : g_first
            tesq_cell u_cell (
               .clock       (clock),
               .op          (op),
               .occupied    (occupied[g]),
               .new_entry   (new_entry),
               .left_entry  (new_entry),
               .right_entry (cell_q[g+1]),
               .left_after  (1'b0),
               .entry       (cell_q[g]),
               .after       (after[g])
            );
         end else if (g == Depth - 1) begin : g_last
            tesq_cell u_cell (
               .clock       (clock),
               .op          (op),
               .occupied    (occupied[g]),
               .new_entry   (new_entry),
               .left_entry  (cell_q[g-1]),
               .right_entry (cell_q[g]),
               .left_after  (after[g-1]),
               .entry       (cell_q[g]),
               .after       (after[g])
            );
         end else begin : g_mid
            tesq_cell u_cell (
               .clock       (clock),
               .op          (op),
               .occupied    (occupied[g]),
               .new_entry   (new_entry),
               .left_entry  (cell_q[g-1]),
               .right_entry (cell_q[g+1]),
               .left_after  (after[g-1]),
               .entry       (cell_q[g]),
               .after       (after[g])
            );
         end
      end
   endgenerate

   assign front_due = (count_ff != '0) && (rel_ff < RW'(tesq_pkg::MaxResults))
                      && (cell_q[0].delay <= now_ff);
   assign next_due  = (count_ff > CW'(1))
                      && ((rel_ff + RW'(1)) < RW'(tesq_pkg::MaxResults))
                      && (cell_q[1].delay <= now_ff);

   always_comb begin
      state_in        = state_ff;
      op              = tesq_pkg::OP_HOLD;
      count_in        = count_ff;
      rel_in          = rel_ff;
      now_in          = now_ff;
      rsp_valid_in    = 1'b0;
      rsp_outcome_in  = rsp_outcome_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_data_one_in = rsp_data_one_ff;
      rsp_data_two_in = rsp_data_two_ff;
      rsp_last_in     = rsp_last_ff;
      case (state_ff)
         tesq_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_kind == tesq_pkg::KIND_ADD) begin
                  if (full) begin
                     rsp_valid_in    = 1'b1;
                     rsp_outcome_in  = tesq_pkg::OUTCOME_DROPPED;
                     rsp_status_in   = req_status_byte;
                     rsp_data_one_in = req_data_one;
                     rsp_data_two_in = req_data_two;
                     rsp_last_in     = 1'b1;
                  end else begin
                     op       = tesq_pkg::OP_INSERT;
                     count_in = count_ff + CW'(1);
                  end
               end else begin
                  now_in   = req_now_time;
                  rel_in   = '0;
                  state_in = tesq_pkg::ST_RELEASE;
               end
            end
         end
         tesq_pkg::ST_RELEASE: begin
            if (front_due) begin
               rsp_valid_in    = 1'b1;
               rsp_outcome_in  = mask_ff[cell_q[0].status[3:0]] ?
                                 tesq_pkg::OUTCOME_LISTENER :
                                 tesq_pkg::OUTCOME_NO_LISTENER;
               rsp_status_in   = cell_q[0].status;
               rsp_data_one_in = cell_q[0].data_one;
               rsp_data_two_in = cell_q[0].data_two;
               rsp_last_in     = !next_due;
               op              = tesq_pkg::OP_SHIFT;
               count_in        = count_ff - CW'(1);
               rel_in          = rel_ff + RW'(1);
            end else begin
               if ((count_ff != '0) && (cell_q[0].delay != 16'd0)) begin
                  op = tesq_pkg::OP_DECR;
               end
               state_in = tesq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tesq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tesq_pkg::ST_IDLE;
         count_ff     <= '0;
         rel_ff       <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rel_ff       <= rel_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mask_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      now_ff          <= now_in;
      rsp_outcome_ff  <= rsp_outcome_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_data_one_ff <= rsp_data_one_in;
      rsp_data_two_ff <= rsp_data_two_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = rsp_outcome_ff;
   assign rsp_channel      = rsp_status_ff[3:0];
   assign rsp_out_status   = rsp_status_ff;
   assign rsp_out_data_one = rsp_data_one_ff;
   assign rsp_out_data_two = rsp_data_two_ff;
   assign rsp_last         = rsp_last_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(Depth))
      else $error("queue count exceeds depth");

   a_drop_when_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_outcome_ff == tesq_pkg::OUTCOME_DROPPED)
      |-> $past(count_ff) == CW'(Depth))
      else $error("drop reported while queue had room");

   a_more_follows : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> state_ff == tesq_pkg::ST_RELEASE)
      else $error("non-final result with no release in progress");

   a_front_sorted : assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(2) |-> cell_q[0].delay <= cell_q[1].delay)
      else $error("front of queue out of order");

   a_add_grows : assert property (@(posedge clock) disable iff (reset)
      accept && (req_kind == tesq_pkg::KIND_ADD) && !full
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("add did not grow the queue");

endmodule
`default_nettype wire

// ===== bench/tesq_event_checker.sv =====
// Checker for the timed event sorted queue: predicts releases and drops, compares results.
`timescale 1ns / 1ps
module tesq_event_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        req_kind,
   input  wire logic [15:0] req_delay,
   input  wire logic [7:0]  req_status_byte,
   input  wire logic [7:0]  req_data_one,
   input  wire logic [7:0]  req_data_two,
   input  wire logic [15:0] req_now_time,
   input  wire logic        rsp_valid,
   input  wire logic [1:0]  rsp_outcome,
   input  wire logic [3:0]  rsp_channel,
   input  wire logic [7:0]  rsp_out_status,
   input  wire logic [7:0]  rsp_out_data_one,
   input  wire logic [7:0]  rsp_out_data_two,
   input  wire logic        rsp_last,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [tesq_pkg::ChannelCount-1:0] csr_wdata,
   output int               fail_count,
   output int               pending,
   output int               results_checked,
   output int               drops_seen
);

   typedef struct {
      logic [1:0] outcome;
      logic [3:0] channel;
      logic [7:0] status;
      logic [7:0] data_one;
      logic [7:0] data_two;
      logic       last;
   } event_result_type;

   tesq_pkg::entry_type queued_events [tesq_pkg::QueueDepth];
   int                queued_count;
   logic [tesq_pkg::ChannelCount-1:0] listener_bits;
   event_result_type  due_results [$];

   initial begin
      fail_count      = 0;
      pending         = 0;
      results_checked = 0;
      drops_seen      = 0;
      queued_count    = 0;
      listener_bits   = '0;
   end

   task automatic push_result(input logic [1:0] outcome, input logic [7:0] st,
                              input logic [7:0] d1, input logic [7:0] d2, input logic last);
      event_result_type r;
      r.outcome  = outcome;
      r.channel  = st[3:0];
      r.status   = st;
      r.data_one = d1;
      r.data_two = d2;
      r.last     = last;
      due_results.insert(due_results.size(), r);
   endtask

   // Sorted insert for adds; release of due events plus delay aging for ticks.
   task automatic sort_and_release(input logic kind, input logic [15:0] dly,
                                   input logic [7:0] st, input logic [7:0] d1,
                                   input logic [7:0] d2, input logic [15:0] now);
      int      pos;
      int      released;
      int      i;
      tesq_pkg::entry_type e;
      if (kind == tesq_pkg::KIND_ADD) begin
         if (queued_count >= tesq_pkg::QueueDepth) begin
            push_result(tesq_pkg::OUTCOME_DROPPED, st, d1, d2, 1'b1);
         end else begin
            pos = 0;
            while (pos < queued_count && queued_events[pos].delay <= dly) pos++;
            for (i = queued_count; i > pos; i--) queued_events[i] = queued_events[i - 1];
            e.delay    = dly;
            e.status   = st;
            e.data_one = d1;
            e.data_two = d2;
            queued_events[pos] = e;
            queued_count++;
         end
      end else begin
         released = 0;
         while (released < queued_count && released < tesq_pkg::MaxResults &&
                queued_events[released].delay <= now) released++;
         for (i = 0; i < released; i++) begin
            e = queued_events[i];
            push_result(listener_bits[e.status[3:0]] ? tesq_pkg::OUTCOME_LISTENER :
                        tesq_pkg::OUTCOME_NO_LISTENER,
                        e.status, e.data_one, e.data_two, i == released - 1);
         end
         if (released > 0) begin
            for (i = released; i < queued_count; i++)
               queued_events[i - released] = queued_events[i];
            queued_count -= released;
         end
         // no aging when the front event is already at zero
         if (queued_count > 0 && queued_events[0].delay >= 16'd1) begin
            for (i = 0; i < queued_count; i++)
               queued_events[i].delay = queued_events[i].delay - 16'd1;
         end
      end
   endtask

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      event_result_type want;
      if (reset) begin
         queued_count  = 0;
         listener_bits = '0;
         due_results.delete();
      end else begin
         if (csr_valid && csr_ready) listener_bits = csr_wdata;
         // results at this edge belong to earlier transfers, so compare first
         if (rsp_valid) begin
            if (due_results.size() == 0) begin
               $error("result with nothing expected: status %0d", rsp_out_status);
               fail_count++;
            end else begin
               want = due_results[0];
               due_results.delete(0);
               check_field("outcome", int'(want.outcome), int'(rsp_outcome));
               check_field("channel", int'(want.channel), int'(rsp_channel));
               check_field("out_status", int'(want.status), int'(rsp_out_status));
               check_field("out_data_one", int'(want.data_one), int'(rsp_out_data_one));
               check_field("out_data_two", int'(want.data_two), int'(rsp_out_data_two));
               check_field("last", int'(want.last), int'(rsp_last));
               if (want.outcome == tesq_pkg::OUTCOME_DROPPED) drops_seen++;
            end
            results_checked++;
         end
         if (start && !busy)
            sort_and_release(req_kind, req_delay, req_status_byte, req_data_one,
                             req_data_two, req_now_time);
      end
      pending = due_results.size();
   end

endmodule

// ===== bench/timed_event_sorted_queue_tb.sv =====
// Testbench top for the timed event sorted queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module timed_event_sorted_queue_tb;

   localparam int QuietLimit  = 2000;
   localparam int SettleCycles = 24;
   localparam int PhaseItems  = 74;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_kind = tesq_pkg::KIND_ADD;
   logic [15:0] req_delay = '0;
   logic [7:0]  req_status_byte = '0;
   logic [7:0]  req_data_one = '0;
   logic [7:0]  req_data_two = '0;
   logic [15:0] req_now_time = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_outcome;
   logic [3:0]  rsp_channel;
   logic [7:0]  rsp_out_status;
   logic [7:0]  rsp_out_data_one;
   logic [7:0]  rsp_out_data_two;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [tesq_pkg::ChannelCount-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int results_checked;
   int drops_seen;
   int quiet_cycles = 0;
   int adds_sent = 0;
   int ticks_sent = 0;
   int mask_writes = 0;
   int no_gap_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   timed_event_sorted_queue uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_delay        (req_delay),
      .req_status_byte  (req_status_byte),
      .req_data_one     (req_data_one),
      .req_data_two     (req_data_two),
      .req_now_time     (req_now_time),
      .rsp_valid        (rsp_valid),
      .rsp_outcome      (rsp_outcome),
      .rsp_channel      (rsp_channel),
      .rsp_out_status   (rsp_out_status),
      .rsp_out_data_one (rsp_out_data_one),
      .rsp_out_data_two (rsp_out_data_two),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   tesq_event_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_delay        (req_delay),
      .req_status_byte  (req_status_byte),
      .req_data_one     (req_data_one),
      .req_data_two     (req_data_two),
      .req_now_time     (req_now_time),
      .rsp_valid        (rsp_valid),
      .rsp_outcome      (rsp_outcome),
      .rsp_channel      (rsp_channel),
      .rsp_out_status   (rsp_out_status),
      .rsp_out_data_one (rsp_out_data_one),
      .rsp_out_data_two (rsp_out_data_two),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending          (pending),
      .results_checked  (results_checked),
      .drops_seen       (drops_seen)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("timeout: no transfer for %0d cycles", quiet_cycles);
            $display("timed_event_sorted_queue_tb: FAIL");
            $finish;
         end
      end
   end

   task automatic write_listener_mask(input logic [tesq_pkg::ChannelCount-1:0] bits);
      csr_valid <= 1'b1;
      csr_wdata <= bits;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mask_writes++;
   endtask

   // start stays high across back-to-back items; lowered only before a gap
   task automatic send_item(input logic kind, input logic [15:0] dly, input logic [7:0] st,
                            input logic [7:0] d1, input logic [7:0] d2,
                            input logic [15:0] now);
      int gap;
      if (no_gap_left > 0) begin
         no_gap_left--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 6);
         if ($urandom_range(0, 19) == 0) no_gap_left = $urandom_range(8, 24);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_kind        <= kind;
      req_delay       <= dly;
      req_status_byte <= st;
      req_data_one    <= d1;
      req_data_two    <= d2;
      req_now_time    <= now;
      do @(posedge clock); while (busy);
      if (kind == tesq_pkg::KIND_ADD) adds_sent++;
      else ticks_sent++;
   endtask

   task automatic drain_queue_results();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic send_random(input int add_percent);
      logic        kind;
      logic [15:0] dly;
      logic [15:0] now;
      int          sel;
      kind = ($urandom_range(0, 99) < add_percent) ? tesq_pkg::KIND_ADD : tesq_pkg::KIND_TICK;
      sel = $urandom_range(0, 9);
      if (sel < 7) dly = 16'($urandom_range(0, 24));
      else if (sel < 9) dly = 16'($urandom);
      else dly = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      sel = $urandom_range(0, 9);
      if (sel < 6) now = 16'($urandom_range(0, 12));
      else if (sel < 8) now = 16'($urandom);
      else now = sel[0] ? 16'hFFFF : 16'h0000;
      send_item(kind, dly, 8'($urandom), 8'($urandom), 8'($urandom), now);
   endtask

   initial begin
      int i;
      int phase;
      int add_percent;
      logic [tesq_pkg::ChannelCount-1:0] bits;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_listener_mask(16'hA5C3);
      send_item(tesq_pkg::KIND_TICK, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      send_item(tesq_pkg::KIND_ADD, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
      send_item(tesq_pkg::KIND_ADD, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      // equal delays must come out in arrival order
      send_item(tesq_pkg::KIND_ADD, 16'd5, 8'h90, 8'h3C, 8'h7F, 16'h0000);
      send_item(tesq_pkg::KIND_ADD, 16'd5, 8'h92, 8'h40, 8'h01, 16'h0000);
      send_item(tesq_pkg::KIND_TICK, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
      send_item(tesq_pkg::KIND_TICK, 16'h0000, 8'h00, 8'h00, 8'h00, 16'hFFFF);
      // fill with falling delays so each add lands at the front
      for (i = 15; i >= 0; i--)
         send_item(tesq_pkg::KIND_ADD, i[15:0], 8'h80 | i[7:0], i[7:0], ~i[7:0], 16'h0000);
      send_item(tesq_pkg::KIND_ADD, 16'd3, 8'hC7, 8'hAA, 8'h55, 16'h0000);
      send_item(tesq_pkg::KIND_TICK, 16'h0000, 8'h00, 8'h00, 8'h00, 16'hFFFF);
      drain_queue_results();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin bits = 16'hFFFF; add_percent = 50; end
            1: begin bits = 16'h0000; add_percent = 75; end
            2: begin bits = 16'($urandom); add_percent = 35; end
            default: begin bits = 16'($urandom); add_percent = 55; end
         endcase
         write_listener_mask(bits);
         for (i = 0; i < PhaseItems; i++) send_random(add_percent);
         drain_queue_results();
      end

      $display("Sent %0d adds and %0d ticks across %0d listener mask settings.",
               adds_sent, ticks_sent, mask_writes);
      $display("Checked %0d results, %0d of them full-queue drops.",
               results_checked, drops_seen);
      if (fail_count == 0) begin
         $display("timed_event_sorted_queue_tb: PASS");
      end else begin
         $display("timed_event_sorted_queue_tb: FAIL");
      end
      $finish;
   end

endmodule
